@@ design/kwm_pkg.sv @@
// Shared types and constants for the k-way sorted merge block.
package kwm_pkg;

  localparam int LIST_BITS = 4;
  localparam int CFG_BITS  = 5;
  localparam int FILL_BITS = 5;

  localparam logic [CFG_BITS-1:0]  NUM_LISTS_RST = 5'd16;
  localparam logic [FILL_BITS-1:0] FILL_SAT      = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_DECIDE,
    ST_POP,
    ST_DN,
    ST_DN_SEL,
    ST_DN_CMP
  } kwm_state_e;

endpackage

@@ design/kwm_if.sv @@
// Valid/ready channel interfaces for the merge input and result streams.
interface kwm_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_BITS-1:0]   value;
  logic [kwm_pkg::LIST_BITS-1:0]  list_id;
  logic                           exhausted;

  modport source (output valid, value, list_id, exhausted, input ready);
  modport sink   (input valid, value, list_id, exhausted, output ready);
endinterface

interface kwm_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_BITS-1:0]   merged_value;
  logic [kwm_pkg::LIST_BITS-1:0]  source_list;
  logic                           done_res;

  modport source (output valid, merged_value, source_list, done_res, input ready);
  modport sink   (input valid, merged_value, source_list, done_res, output ready);
endinterface

@@ design/kwm_cmp.sv @@
// Heap order compare: signed value first, smaller list index wins a tie.
module kwm_cmp #(
  parameter int VALUE_BITS = 32
) (
  input  logic signed [VALUE_BITS-1:0]  a_val_i,
  input  logic [kwm_pkg::LIST_BITS-1:0] a_lst_i,
  input  logic signed [VALUE_BITS-1:0]  b_val_i,
  input  logic [kwm_pkg::LIST_BITS-1:0] b_lst_i,
  output logic                          before_o
);

  logic val_lt;
  logic val_eq;

  assign val_lt   = a_val_i < b_val_i;
  assign val_eq   = a_val_i == b_val_i;
  assign before_o = val_lt || (val_eq && (a_lst_i < b_lst_i));

endmodule

@@ design/k_way_sorted_merge.sv @@
// K-way merge of ascending sorted lists through a min-heap of (value, list) entries.
// A run starts with a fill phase: num_lists transactions, one per list, each carrying
// that list's head (list_id names the list) or an exhausted mark for an empty list.
// After the last fill transaction, and after every later one, the block pops the
// smallest entry (equal values go to the smaller list index) and returns it with its
// source_list. The next input transaction must be that list's successor or an
// exhausted mark; its list_id is not looked at. When an exhausted mark leaves the heap
// empty, a result with done_res set and zero payload closes the run and the block goes
// back to fill. The user must write num_lists only between runs; the block does not
// enforce it. 0 acts as 1 and values above MAX_LISTS act as MAX_LISTS. The heap lives
// in a small memory with one write port and two registered read ports, and a single
// comparator is stepped by a sequencer, so one transaction at a time is worked on and
// in_i.ready is low meanwhile. Steps per transaction: accept; a push that climbs level
// by level (none for an exhausted mark or a full heap); decide; a pop that takes the
// root, refills it with the last entry and sifts it down level by level (no sift when
// the last entry was taken). A result that is not yet taken holds the sequencer at the
// decide step. The heap needs no clearing after reset: only entries below the current
// size are ever used.
module k_way_sorted_merge #(
  parameter int MAX_LISTS  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kwm_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  kwm_in_if.sink                        in_i,
  kwm_out_if.source                     out_o
);

  localparam int IW = $clog2(MAX_LISTS);
  localparam int SW = $clog2(MAX_LISTS + 1);
  localparam int CW = (SW > kwm_pkg::CFG_BITS) ? SW : kwm_pkg::CFG_BITS;
  localparam int LW = kwm_pkg::LIST_BITS;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic [LW-1:0]         lst;
  } entry_t;

  // control state
  kwm_pkg::kwm_state_e state_q, state_d;
  logic [kwm_pkg::CFG_BITS-1:0]  num_lists_q;
  logic [SW-1:0]                 size_q;
  logic [kwm_pkg::FILL_BITS-1:0] fill_q;
  logic                          merging_q;
  logic [LW-1:0]                 pending_q;
  logic                          emit_q;
  logic                          out_valid_q;

  // payload / datapath
  entry_t        item_q;
  entry_t        cand_q;
  entry_t        rd_a_q;
  entry_t        rd_b_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] cand_idx_q;
  logic          right_q;
  logic [VALUE_BITS-1:0] out_val_q;
  logic [LW-1:0]         out_lst_q;
  logic                  out_done_q;

  entry_t heap_mem [MAX_LISTS];

  // decoded helpers
  logic                          in_fire;
  logic                          out_free;
  logic                          out_load;
  logic                          push_ok;
  logic [CW-1:0]                 num_ext;
  logic [CW-1:0]                 n_eff;
  logic [kwm_pkg::FILL_BITS-1:0] fill_inc;
  logic                          fill_last;
  logic [SW:0]                   size_ext;
  logic [SW:0]                   child_l;
  logic [SW:0]                   child_r;
  logic                          has_l;
  logic                          has_r;
  logic [IW-1:0]                 idx_m1;
  logic [IW-1:0]                 parent_idx;
  logic [SW-1:0]                 size_m1;

  // sequencer strobes
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] rd_a_addr;
  logic [IW-1:0] rd_b_addr;
  entry_t        cmp_a;
  entry_t        cmp_b;
  logic          cmp_before;

  assign in_i.ready = (state_q == kwm_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign push_ok    = !in_i.exhausted && (size_q < SW'(MAX_LISTS));

  // result register loads: a popped entry, or the done result on an empty heap
  assign out_load = (state_q == kwm_pkg::ST_POP) ||
                    ((state_q == kwm_pkg::ST_DECIDE) && emit_q && out_free &&
                     (size_q == '0));

  // clamp of the list count, taken at every fill step
  assign num_ext = CW'(num_lists_q);
  always_comb begin
    if (num_ext == '0) begin
      n_eff = CW'(1);
    end else if (num_ext > CW'(MAX_LISTS)) begin
      n_eff = CW'(MAX_LISTS);
    end else begin
      n_eff = num_ext;
    end
  end

  assign fill_inc  = (fill_q != kwm_pkg::FILL_SAT) ? fill_q + 1'b1 : fill_q;
  assign fill_last = CW'(fill_inc) >= n_eff;

  // heap index arithmetic
  assign size_ext   = (SW + 1)'(size_q);
  assign child_l    = ((SW + 1)'(idx_q) << 1) | (SW + 1)'(1);
  assign child_r    = child_l + (SW + 1)'(1);
  assign has_l      = child_l < size_ext;
  assign has_r      = child_r < size_ext;
  assign idx_m1     = idx_q - IW'(1);
  assign parent_idx = idx_m1 >> 1;
  assign size_m1    = size_q - SW'(1);

  kwm_cmp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .a_val_i  (cmp_a.val),
    .a_lst_i  (cmp_a.lst),
    .b_val_i  (cmp_b.val),
    .b_lst_i  (cmp_b.lst),
    .before_o (cmp_before)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = push_ok ? kwm_pkg::ST_UP : kwm_pkg::ST_DECIDE;
        end
      end
      kwm_pkg::ST_UP: begin
        state_d = (idx_q == '0) ? kwm_pkg::ST_DECIDE : kwm_pkg::ST_UP_CMP;
      end
      kwm_pkg::ST_UP_CMP: begin
        state_d = cmp_before ? kwm_pkg::ST_UP : kwm_pkg::ST_DECIDE;
      end
      kwm_pkg::ST_DECIDE: begin
        if (!emit_q) begin
          state_d = kwm_pkg::ST_IDLE;
        end else if (out_free) begin
          state_d = (size_q == '0) ? kwm_pkg::ST_IDLE : kwm_pkg::ST_POP;
        end
      end
      kwm_pkg::ST_POP: begin
        state_d = (size_q == SW'(1)) ? kwm_pkg::ST_IDLE : kwm_pkg::ST_DN;
      end
      kwm_pkg::ST_DN: begin
        state_d = has_l ? kwm_pkg::ST_DN_SEL : kwm_pkg::ST_IDLE;
      end
      kwm_pkg::ST_DN_SEL: begin
        state_d = kwm_pkg::ST_DN_CMP;
      end
      kwm_pkg::ST_DN_CMP: begin
        state_d = cmp_before ? kwm_pkg::ST_DN : kwm_pkg::ST_IDLE;
      end
      default: begin
        state_d = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: memory port and comparator operand steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = item_q;
    rd_a_addr = '0;
    rd_b_addr = '0;
    cmp_a     = item_q;
    cmp_b     = rd_a_q;
    case (state_q)
      kwm_pkg::ST_UP: begin
        if (idx_q == '0) begin
          mem_we = 1'b1;
        end else begin
          rd_a_addr = parent_idx;
        end
      end
      kwm_pkg::ST_UP_CMP: begin
        // hole moves up: parent drops into it, or the new entry lands
        mem_we = 1'b1;
        if (cmp_before) begin
          mem_wdata = rd_a_q;
        end
      end
      kwm_pkg::ST_DECIDE: begin
        rd_a_addr = '0;
        rd_b_addr = (size_q == '0) ? '0 : size_m1[IW-1:0];
      end
      kwm_pkg::ST_DN: begin
        if (!has_l) begin
          mem_we = 1'b1;
        end else begin
          rd_a_addr = child_l[IW-1:0];
          rd_b_addr = has_r ? child_r[IW-1:0] : child_l[IW-1:0];
        end
      end
      kwm_pkg::ST_DN_SEL: begin
        cmp_a = rd_b_q;
        cmp_b = rd_a_q;
      end
      kwm_pkg::ST_DN_CMP: begin
        cmp_a  = cand_q;
        cmp_b  = item_q;
        mem_we = 1'b1;
        if (cmp_before) begin
          mem_wdata = cand_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // heap storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kwm_pkg::ST_IDLE;
      num_lists_q <= kwm_pkg::NUM_LISTS_RST;
      size_q      <= '0;
      fill_q      <= '0;
      merging_q   <= 1'b0;
      pending_q   <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_lists_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        kwm_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (push_ok) begin
              size_q <= size_q + SW'(1);
            end
            if (merging_q) begin
              emit_q <= 1'b1;
            end else begin
              fill_q <= fill_inc;
              emit_q <= fill_last;
            end
          end
        end
        kwm_pkg::ST_DECIDE: begin
          // empty heap at emit time: done result, back to fill
          if (emit_q && out_free && (size_q == '0)) begin
            out_valid_q <= 1'b1;
            merging_q   <= 1'b0;
            fill_q      <= '0;
            pending_q   <= '0;
          end
        end
        kwm_pkg::ST_POP: begin
          out_valid_q <= 1'b1;
          merging_q   <= 1'b1;
          pending_q   <= rd_a_q.lst;
          size_q      <= size_m1;
        end
        default: begin
          emit_q <= emit_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_q.val <= in_i.value;
          item_q.lst <= merging_q ? pending_q : in_i.list_id;
          idx_q      <= size_q[IW-1:0];
        end
      end
      kwm_pkg::ST_UP_CMP: begin
        if (cmp_before) begin
          idx_q <= parent_idx;
        end
      end
      kwm_pkg::ST_DECIDE: begin
        if (emit_q && out_free && (size_q == '0)) begin
          out_val_q  <= '0;
          out_lst_q  <= '0;
          out_done_q <= 1'b1;
        end
      end
      kwm_pkg::ST_POP: begin
        out_val_q  <= rd_a_q.val;
        out_lst_q  <= rd_a_q.lst;
        out_done_q <= 1'b0;
        item_q     <= rd_b_q;   // last entry refills the root
        idx_q      <= '0;
      end
      kwm_pkg::ST_DN: begin
        right_q <= has_r;
      end
      kwm_pkg::ST_DN_SEL: begin
        if (right_q && cmp_before) begin
          cand_q     <= rd_b_q;
          cand_idx_q <= child_r[IW-1:0];
        end else begin
          cand_q     <= rd_a_q;
          cand_idx_q <= child_l[IW-1:0];
        end
      end
      kwm_pkg::ST_DN_CMP: begin
        if (cmp_before) begin
          idx_q <= cand_idx_q;
        end
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_val_q;
  assign out_o.source_list  = out_lst_q;
  assign out_o.done_res     = out_done_q;

endmodule
